// File: sv/swmc_pkg.sv
// Package for the shrinking wall move check.
// Holds the shape codes, register indexes, sequencer states and shared constants.
// No dependencies.
package swmc_pkg;

  // Default coordinate width (signed Q16.16)
  localparam int unsigned COORD_WIDTH_DEF = 32;

  // Wall shrink per step: 0.02 in Q16.16
  localparam logic [30:0] DR_Q16 = 31'd1311;

  typedef enum logic [1:0] {
    SHAPE_FLAT      = 2'd0,
    SHAPE_CUBOID    = 2'd1,
    SHAPE_ELLIPSOID = 2'd2,
    SHAPE_SHELL     = 2'd3
  } shape_e;

  typedef enum logic [2:0] {
    CFG_SHAPE    = 3'd0,
    CFG_EQ_TIME  = 3'd1,
    CFG_TARGET_X = 3'd2,
    CFG_TARGET_Y = 3'd3,
    CFG_TARGET_Z = 3'd4,
    CFG_START_X  = 3'd5,
    CFG_START_Y  = 3'd6,
    CFG_START_Z  = 3'd7
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHK,
    ST_MX,
    ST_MX_ACC,
    ST_TMUL,
    ST_TLOAD,
    ST_TDIV,
    ST_TSQ,
    ST_TACC,
    ST_MET_DONE,
    ST_BA,
    ST_BB,
    ST_CMP,
    ST_ROOT,
    ST_DIST,
    ST_FIN
  } state_e;

endpackage

// File: sv/swmc_if.sv
// Request and response channel interfaces of the shrinking wall move check.
// Valid/ready handshake; depends on nothing.
interface swmc_req_if;
  logic        valid;
  logic        ready;
  logic [30:0] step;
  logic        all_inside;
  logic [31:0] pos_x;
  logic [31:0] pos_y;
  logic [31:0] pos_z;
  logic [31:0] move_x;
  logic [31:0] move_y;
  logic [31:0] move_z;

  modport source (output valid, step, all_inside, pos_x, pos_y, pos_z,
                  move_x, move_y, move_z, input ready);
  modport sink   (input valid, step, all_inside, pos_x, pos_y, pos_z,
                  move_x, move_y, move_z, output ready);
endinterface

interface swmc_rsp_if;
  logic valid;
  logic ready;
  logic accept;
  logic target_reached;

  modport source (output valid, accept, target_reached, input ready);
  modport sink   (input valid, accept, target_reached, output ready);
endinterface

// File: sv/shrinking_wall_move_check.sv
// Flat and cuboid walls go straight from the check state to the response.
// Ellipsoid and shell walls also compute a metric (up to two divisions plus squaring);
// a shell point that lands outside an unreached wall takes two metrics and two
// square roots. One request at a time: set by the shared multiplier and the
// shared 1-bit-per-cycle shift-subtract unit.
// Reset clears the configuration, the wall, the reached flag and the sequencer.
module shrinking_wall_move_check #(
  parameter int unsigned COORD_WIDTH = swmc_pkg::COORD_WIDTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [30:0] cfg_data_i,
  swmc_req_if.sink    req_i,
  swmc_rsp_if.source  rsp_o
);

  localparam int unsigned CW = (COORD_WIDTH < 32) ? COORD_WIDTH : 32;
  localparam logic signed [32:0] CoHi = (33'sd1 <<< (CW - 1)) - 33'sd1;
  localparam logic signed [32:0] CoLo = -CoHi - 33'sd1;

  // Configuration and wall state
  swmc_pkg::shape_e shape_q;
  logic [30:0] eq_time_q, tgt_x_q, tgt_y_q, tgt_z_q, st_y_q;
  logic [30:0] wall_x_q, wall_y_q, wall_z_q;
  logic [30:0] wall_x_d, wall_y_d, wall_z_d;
  logic        reached_q, reached_d;
  logic [30:0] last_step_q, last_step_d;

  // Sequencer and datapath
  swmc_pkg::state_e state_q, state_d;
  logic signed [31:0] p0_q [3];
  logic signed [31:0] p1_q [3];
  logic signed [31:0] p0_d [3];
  logic signed [31:0] p1_d [3];
  logic [63:0] mul_q, acc_q, acc_d, bnd_q, bnd_d, work_q, work_d;
  logic [35:0] rem_q, rem_d;
  logic [31:0] root_q, root_d, root1_q, root1_d;
  logic [31:0] mul_a, mul_b;
  logic [4:0]  cnt_q, cnt_d;
  logic        pt_q, pt_d, ax_q, ax_d, ok_q, ok_d;
  logic        ov_q, ov_d, oacc_q, oacc_d, orch_q, orch_d;

  logic        req_fire;
  logic signed [31:0] psel [3];
  logic [31:0] abs_x, abs_ax, abs_z1, abs_z0;
  logic [30:0] den;
  logic [32:0] rem2;
  logic        div_ge;
  logic [35:0] r4, trial;
  logic        root_ge;
  logic [31:0] root_nx;
  logic [30:0] half;
  logic [31:0] outer, inner;
  logic [64:0] acc_sum;
  logic        ins_ell;
  logic [32:0] d1, d0;

  function automatic logic [31:0] abs32(logic signed [31:0] v);
    return v[31] ? 32'(-v) : 32'(v);
  endfunction

  function automatic logic signed [31:0] sat_pos(logic [31:0] p, logic [31:0] m);
    logic signed [CW-1:0] ps;
    logic signed [CW-1:0] ms;
    logic signed [32:0]   s;
    ps = p[CW-1:0];
    ms = m[CW-1:0];
    s  = 33'(ps) + 33'(ms);
    if (s > CoHi) s = CoHi;
    else if (s < CoLo) s = CoLo;
    return s[31:0];
  endfunction

  function automatic logic [30:0] shrink_axis(logic [30:0] w, logic [30:0] t);
    logic signed [31:0] diff;
    diff = $signed({1'b0, w}) - $signed({1'b0, t});
    return (diff < $signed({1'b0, swmc_pkg::DR_Q16})) ? t : w - swmc_pkg::DR_Q16;
  endfunction

  assign req_fire    = req_i.valid && req_i.ready;
  assign req_i.ready = (state_q == swmc_pkg::ST_IDLE);

  assign rsp_o.valid          = ov_q;
  assign rsp_o.accept         = oacc_q;
  assign rsp_o.target_reached = orch_q;

  // Operand selects for the metric
  always_comb begin
    for (int i = 0; i < 3; i++) psel[i] = pt_q ? p0_q[i] : p1_q[i];
    abs_x  = abs32(psel[0]);
    abs_ax = ax_q ? abs32(psel[2]) : abs32(psel[1]);
    abs_z1 = abs32(p1_q[2]);
    abs_z0 = abs32(p0_q[2]);
    den    = ax_q ? tgt_z_q : tgt_y_q;
  end

  // Shift-subtract unit: division step and square-root step
  always_comb begin
    rem2    = {rem_q[31:0], work_q[63]};
    div_ge  = rem2 >= {2'b0, den};
    r4      = {rem_q[33:0], work_q[63:62]};
    trial   = {2'b0, root_q, 2'b01};
    root_ge = r4 >= trial;
    root_nx = {root_q[30:0], root_ge};
  end

  // Shell bounds and metric accumulate
  always_comb begin
    half    = wall_z_q >> 1;
    outer   = {1'b0, wall_x_q} + {1'b0, half};
    inner   = (wall_x_q >= half) ? {1'b0, wall_x_q - half} : {1'b0, half - wall_x_q};
    acc_sum = {1'b0, acc_q} + {1'b0, mul_q};
    ins_ell = (shape_q == swmc_pkg::SHAPE_ELLIPSOID) ? (acc_q <= bnd_q)
                                                     : !(acc_q > bnd_q || acc_q < mul_q);
    d1 = (root1_q >= {1'b0, wall_x_q}) ? {1'b0, root1_q - {1'b0, wall_x_q}}
                                       : {1'b0, {1'b0, wall_x_q} - root1_q};
    d0 = (root_q >= {1'b0, wall_x_q}) ? {1'b0, root_q - {1'b0, wall_x_q}}
                                      : {1'b0, {1'b0, wall_x_q} - root_q};
  end

  // Shared multiplier operands
  always_comb begin
    case (state_q)
      swmc_pkg::ST_MX:   begin mul_a = abs_x;           mul_b = abs_x;           end
      swmc_pkg::ST_TMUL: begin mul_a = {1'b0, tgt_x_q}; mul_b = abs_ax;          end
      swmc_pkg::ST_TSQ:  begin mul_a = work_q[31:0];    mul_b = work_q[31:0];    end
      swmc_pkg::ST_BA: begin
        if (shape_q == swmc_pkg::SHAPE_ELLIPSOID) begin
          mul_a = {1'b0, wall_x_q};
          mul_b = {1'b0, wall_x_q};
        end else begin
          mul_a = outer;
          mul_b = outer;
        end
      end
      swmc_pkg::ST_BB:   begin mul_a = inner;           mul_b = inner;           end
      default:           begin mul_a = '0;              mul_b = '0;              end
    endcase
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      swmc_pkg::ST_IDLE: if (req_i.valid) state_d = swmc_pkg::ST_CHK;
      swmc_pkg::ST_CHK: begin
        if (shape_q == swmc_pkg::SHAPE_FLAT || shape_q == swmc_pkg::SHAPE_CUBOID)
          state_d = swmc_pkg::ST_FIN;
        else
          state_d = swmc_pkg::ST_MX;
      end
      swmc_pkg::ST_MX:     state_d = swmc_pkg::ST_MX_ACC;
      swmc_pkg::ST_MX_ACC: state_d = swmc_pkg::ST_TMUL;
      swmc_pkg::ST_TMUL:   state_d = swmc_pkg::ST_TLOAD;
      swmc_pkg::ST_TLOAD: begin
        if (den == '0 || mul_q[63:32] >= {1'b0, den}) state_d = swmc_pkg::ST_TSQ;
        else state_d = swmc_pkg::ST_TDIV;
      end
      swmc_pkg::ST_TDIV:   if (cnt_q == 5'd31) state_d = swmc_pkg::ST_TSQ;
      swmc_pkg::ST_TSQ:    state_d = swmc_pkg::ST_TACC;
      swmc_pkg::ST_TACC:   state_d = ax_q ? swmc_pkg::ST_MET_DONE : swmc_pkg::ST_TMUL;
      swmc_pkg::ST_MET_DONE: state_d = pt_q ? swmc_pkg::ST_ROOT : swmc_pkg::ST_BA;
      swmc_pkg::ST_BA:     state_d = swmc_pkg::ST_BB;
      swmc_pkg::ST_BB:     state_d = swmc_pkg::ST_CMP;
      swmc_pkg::ST_CMP: begin
        if (ins_ell || reached_q || shape_q != swmc_pkg::SHAPE_SHELL)
          state_d = swmc_pkg::ST_FIN;
        else
          state_d = swmc_pkg::ST_ROOT;
      end
      swmc_pkg::ST_ROOT: begin
        if (cnt_q == 5'd31) state_d = pt_q ? swmc_pkg::ST_DIST : swmc_pkg::ST_MX;
      end
      swmc_pkg::ST_DIST:   state_d = swmc_pkg::ST_FIN;
      swmc_pkg::ST_FIN:    if (!ov_q || rsp_o.ready) state_d = swmc_pkg::ST_IDLE;
      default:             state_d = swmc_pkg::ST_IDLE;
    endcase
  end

  // Wall update taken on the accepted request or on a start write
  always_comb begin
    wall_x_d    = wall_x_q;
    wall_y_d    = wall_y_q;
    wall_z_d    = wall_z_q;
    reached_d   = reached_q;
    last_step_d = last_step_q;
    for (int i = 0; i < 3; i++) begin
      p0_d[i] = p0_q[i];
      p1_d[i] = p1_q[i];
    end
    if (req_fire) begin
      p0_d[0] = sat_pos(req_i.pos_x, 32'd0);
      p0_d[1] = sat_pos(req_i.pos_y, 32'd0);
      p0_d[2] = sat_pos(req_i.pos_z, 32'd0);
      p1_d[0] = sat_pos(req_i.pos_x, req_i.move_x);
      p1_d[1] = sat_pos(req_i.pos_y, req_i.move_y);
      p1_d[2] = sat_pos(req_i.pos_z, req_i.move_z);
      if (!reached_q) begin
        if (req_i.step < eq_time_q) begin
          if (req_i.all_inside && req_i.step != last_step_q) begin
            last_step_d = req_i.step;
            case (shape_q)
              swmc_pkg::SHAPE_FLAT: begin
                wall_z_d  = shrink_axis(wall_z_q, tgt_z_q);
                reached_d = (wall_z_d == tgt_z_q);
              end
              swmc_pkg::SHAPE_CUBOID: begin
                wall_x_d  = shrink_axis(wall_x_q, tgt_x_q);
                wall_y_d  = shrink_axis(wall_y_q, tgt_y_q);
                wall_z_d  = shrink_axis(wall_z_q, tgt_z_q);
                reached_d = (wall_x_d == tgt_x_q) && (wall_y_d == tgt_y_q) &&
                            (wall_z_d == tgt_z_q);
              end
              swmc_pkg::SHAPE_ELLIPSOID: begin
                wall_x_d  = shrink_axis(wall_x_q, tgt_x_q);
                reached_d = (wall_x_d == tgt_x_q);
              end
              default: ;
            endcase
          end
        end else begin
          // at or after eq time: snap to target (shell: wall z takes the start y)
          reached_d = 1'b1;
          case (shape_q)
            swmc_pkg::SHAPE_FLAT:      wall_z_d = tgt_z_q;
            swmc_pkg::SHAPE_CUBOID: begin
              wall_x_d = tgt_x_q;
              wall_y_d = tgt_y_q;
              wall_z_d = tgt_z_q;
            end
            swmc_pkg::SHAPE_ELLIPSOID: wall_x_d = tgt_x_q;
            default:                   wall_z_d = st_y_q;
          endcase
        end
      end
    end
    // start writes reload the wall
    if (cfg_we_i) begin
      case (swmc_pkg::cfg_idx_e'(cfg_idx_i))
        swmc_pkg::CFG_START_X: wall_x_d = cfg_data_i;
        swmc_pkg::CFG_START_Y: wall_y_d = cfg_data_i;
        swmc_pkg::CFG_START_Z: wall_z_d = cfg_data_i;
        default: ;
      endcase
    end
  end

  // Datapath registers next values
  always_comb begin
    acc_d   = acc_q;
    bnd_d   = bnd_q;
    work_d  = work_q;
    rem_d   = rem_q;
    root_d  = root_q;
    root1_d = root1_q;
    cnt_d   = cnt_q;
    pt_d    = pt_q;
    ax_d    = ax_q;
    ok_d    = ok_q;
    case (state_q)
      swmc_pkg::ST_CHK: begin
        pt_d = 1'b0;
        if (shape_q == swmc_pkg::SHAPE_FLAT)
          ok_d = (abs_z1 <= {1'b0, wall_z_q}) || !(reached_q || abs_z1 > abs_z0);
        else
          ok_d = (abs32(p1_q[0]) <= {1'b0, wall_x_q}) &&
                 (abs32(p1_q[1]) <= {1'b0, wall_y_q}) &&
                 (abs_z1 <= {1'b0, wall_z_q});
      end
      swmc_pkg::ST_MX_ACC: begin
        acc_d = mul_q;
        ax_d  = 1'b0;
      end
      swmc_pkg::ST_TLOAD: begin
        cnt_d = '0;
        if (den == '0) begin
          work_d = (abs_ax != '0) ? {32'd0, 32'hFFFF_FFFF} : 64'd0;
        end else if (mul_q[63:32] >= {1'b0, den}) begin
          work_d = {32'd0, 32'hFFFF_FFFF};
        end else begin
          rem_d  = {4'd0, mul_q[63:32]};
          work_d = {mul_q[31:0], 32'd0};
        end
      end
      swmc_pkg::ST_TDIV: begin
        rem_d  = {3'd0, div_ge ? rem2 - {2'b0, den} : rem2};
        work_d = {work_q[62:0], div_ge};
        cnt_d  = cnt_q + 5'd1;
      end
      swmc_pkg::ST_TACC: begin
        acc_d = acc_sum[64] ? '1 : acc_sum[63:0];
        ax_d  = 1'b1;
      end
      swmc_pkg::ST_MET_DONE: begin
        if (pt_q) begin
          work_d = acc_q;
          rem_d  = '0;
          root_d = '0;
          cnt_d  = '0;
        end
      end
      swmc_pkg::ST_BB: bnd_d = mul_q;
      swmc_pkg::ST_CMP: begin
        ok_d   = ins_ell;
        work_d = acc_q;
        rem_d  = '0;
        root_d = '0;
        cnt_d  = '0;
      end
      swmc_pkg::ST_ROOT: begin
        rem_d  = root_ge ? r4 - trial : r4;
        root_d = root_nx;
        work_d = {work_q[61:0], 2'b00};
        cnt_d  = cnt_q + 5'd1;
        if (cnt_q == 5'd31 && !pt_q) begin
          root1_d = root_nx;
          pt_d    = 1'b1;
        end
      end
      swmc_pkg::ST_DIST: ok_d = !(d1 > d0);
      default: ;
    endcase
  end

  // Response register
  always_comb begin
    ov_d   = ov_q;
    oacc_d = oacc_q;
    orch_d = orch_q;
    if (ov_q && rsp_o.ready) ov_d = 1'b0;
    if (state_q == swmc_pkg::ST_FIN && (!ov_q || rsp_o.ready)) begin
      ov_d   = 1'b1;
      oacc_d = ok_q;
      orch_d = reached_q;
    end
  end

  // Control and wall registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= swmc_pkg::ST_IDLE;
      shape_q     <= swmc_pkg::SHAPE_FLAT;
      eq_time_q   <= '0;
      tgt_x_q     <= '0;
      tgt_y_q     <= '0;
      tgt_z_q     <= '0;
      st_y_q      <= '0;
      wall_x_q    <= '0;
      wall_y_q    <= '0;
      wall_z_q    <= '0;
      reached_q   <= 1'b0;
      last_step_q <= '0;
      ov_q        <= 1'b0;
      cnt_q       <= '0;
      pt_q        <= 1'b0;
      ax_q        <= 1'b0;
    end else begin
      state_q     <= state_d;
      reached_q   <= reached_d;
      last_step_q <= last_step_d;
      ov_q        <= ov_d;
      cnt_q       <= cnt_d;
      pt_q        <= pt_d;
      ax_q        <= ax_d;
      wall_x_q    <= wall_x_d;
      wall_y_q    <= wall_y_d;
      wall_z_q    <= wall_z_d;
      if (cfg_we_i) begin
        case (swmc_pkg::cfg_idx_e'(cfg_idx_i))
          swmc_pkg::CFG_SHAPE:    shape_q   <= swmc_pkg::shape_e'(cfg_data_i[1:0]);
          swmc_pkg::CFG_EQ_TIME:  eq_time_q <= cfg_data_i;
          swmc_pkg::CFG_TARGET_X: tgt_x_q   <= cfg_data_i;
          swmc_pkg::CFG_TARGET_Y: tgt_y_q   <= cfg_data_i;
          swmc_pkg::CFG_TARGET_Z: tgt_z_q   <= cfg_data_i;
          swmc_pkg::CFG_START_Y:  st_y_q    <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      p0_q[i] <= p0_d[i];
      p1_q[i] <= p1_d[i];
    end
    mul_q   <= mul_a * mul_b;
    acc_q   <= acc_d;
    bnd_q   <= bnd_d;
    work_q  <= work_d;
    rem_q   <= rem_d;
    root_q  <= root_d;
    root1_q <= root1_d;
    ok_q    <= ok_d;
    oacc_q  <= oacc_d;
    orch_q  <= orch_d;
  end

  // Checks
  a_reached_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(reached_q) |-> reached_q)
    else $error("reached flag cleared");

  a_div_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == swmc_pkg::ST_TDIV |-> rem_q[32:0] < {2'b0, den})
    else $error("division remainder out of range");

  a_root_shell_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == swmc_pkg::ST_ROOT |-> shape_q == swmc_pkg::SHAPE_SHELL)
    else $error("square root entered for non-shell wall");

  a_req_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_fire |=> state_q == swmc_pkg::ST_CHK)
    else $error("accepted request not started");

endmodule

// File: sim/tb_shrinking_wall_move_check.sv
// Testbench for shrinking_wall_move_check: random and directed move requests checked
// against a wall predictor held in a small scoreboard class.
// Depends on swmc_pkg and the swmc_req_if / swmc_rsp_if interfaces.
module tb_shrinking_wall_move_check;
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint unsigned TERM_CAP = 64'hFFFF_FFFF;
  localparam longint          SHRINK_Q16 = 1311;
  localparam int              CYCLE_LIMIT = 3_000_000;
  localparam logic [30:0]     MAX31 = 31'h7FFF_FFFF;

  typedef struct {
    logic [30:0]      step;
    logic             all_inside;
    logic [2:0][31:0] pos;
    logic [2:0][31:0] mv;
  } move_req_t;

  typedef struct {
    logic accept;
    logic target_reached;
  } move_rsp_t;

  // Wall predictor plus the queue of expected responses
  class wall_scoreboard;
    swmc_pkg::shape_e  shape;
    logic [30:0]       eq_time, tgt_x, tgt_y, tgt_z, st_y;
    longint            wall_x, wall_y, wall_z;
    bit                reached;
    logic [30:0]       last_step;
    move_rsp_t         expected[$];
    int                errors;

    function void clear();
      shape = swmc_pkg::SHAPE_FLAT;
      eq_time = 0; tgt_x = 0; tgt_y = 0; tgt_z = 0; st_y = 0;
      wall_x = 0; wall_y = 0; wall_z = 0;
      reached = 0; last_step = 0; errors = 0;
      expected.delete();
    endfunction

    function void write_reg(swmc_pkg::cfg_idx_e idx, logic [30:0] val);
      case (idx)
        swmc_pkg::CFG_SHAPE:    shape = swmc_pkg::shape_e'(val[1:0]);
        swmc_pkg::CFG_EQ_TIME:  eq_time = val;
        swmc_pkg::CFG_TARGET_X: tgt_x = val;
        swmc_pkg::CFG_TARGET_Y: tgt_y = val;
        swmc_pkg::CFG_TARGET_Z: tgt_z = val;
        swmc_pkg::CFG_START_X:  wall_x = longint'(val);
        swmc_pkg::CFG_START_Y:  begin st_y = val; wall_y = longint'(val); end
        swmc_pkg::CFG_START_Z:  wall_z = longint'(val);
        default: ;
      endcase
    endfunction

    static function longint unsigned mag(longint v);
      return v < 0 ? longint'(-v) : v;
    endfunction

    static function longint unsigned add_sat(longint unsigned a, longint unsigned b);
      logic [64:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[64] ? '1 : s[63:0];
    endfunction

    static function longint unsigned floor_sqrt(longint unsigned x);
      longint unsigned res, bt;
      res = 0;
      bt = 64'd1 << 62;
      while (bt > x) bt >>= 2;
      while (bt != 0) begin
        if (x >= res + bt) begin
          x -= res + bt;
          res = (res >> 1) + bt;
        end else begin
          res >>= 1;
        end
        bt >>= 2;
      end
      return res;
    endfunction

    // A*|d|/den, capped; a zero divisor gives zero or the cap
    function longint unsigned axis_term(longint unsigned ad, logic [30:0] den);
      longint unsigned q;
      if (den == 0) return ad != 0 ? TERM_CAP : 0;
      q = (longint'(tgt_x) * ad) / longint'(den);
      return q > TERM_CAP ? TERM_CAP : q;
    endfunction

    function longint unsigned radius_sq(longint p[3]);
      longint unsigned ax, qy, qz;
      ax = mag(p[0]);
      qy = axis_term(mag(p[1]), tgt_y);
      qz = axis_term(mag(p[2]), tgt_z);
      return add_sat(add_sat(ax * ax, qy * qy), qz * qz);
    endfunction

    function bit is_inside(longint p[3]);
      longint unsigned r2, outer, inner;
      longint half;
      case (shape)
        swmc_pkg::SHAPE_FLAT:   return mag(p[2]) <= wall_z;
        swmc_pkg::SHAPE_CUBOID: return mag(p[0]) <= wall_x && mag(p[1]) <= wall_y &&
                                       mag(p[2]) <= wall_z;
        swmc_pkg::SHAPE_ELLIPSOID:
          return radius_sq(p) <= longint'(wall_x) * longint'(wall_x);
        default: begin
          r2 = radius_sq(p);
          half = wall_z >>> 1;
          outer = wall_x + half;
          inner = mag(wall_x - half);
          return !(r2 > outer * outer || r2 < inner * inner);
        end
      endcase
    endfunction

    function longint unsigned bound_dist(longint p[3]);
      if (shape == swmc_pkg::SHAPE_FLAT) return mag(p[2]);
      if (shape == swmc_pkg::SHAPE_SHELL)
        return mag(longint'(floor_sqrt(radius_sq(p))) - wall_x);
      return 0;
    endfunction

    static function longint step_axis(longint w, logic [30:0] t);
      return (w - longint'(t) < SHRINK_Q16) ? longint'(t) : w - SHRINK_Q16;
    endfunction

    function void shrink_wall();
      case (shape)
        swmc_pkg::SHAPE_FLAT: begin
          wall_z = step_axis(wall_z, tgt_z);
          if (wall_z == tgt_z) reached = 1;
        end
        swmc_pkg::SHAPE_CUBOID: begin
          wall_x = step_axis(wall_x, tgt_x);
          wall_y = step_axis(wall_y, tgt_y);
          wall_z = step_axis(wall_z, tgt_z);
          if (wall_x == tgt_x && wall_y == tgt_y && wall_z == tgt_z) reached = 1;
        end
        swmc_pkg::SHAPE_ELLIPSOID: begin
          wall_x = step_axis(wall_x, tgt_x);
          if (wall_x == tgt_x) reached = 1;
        end
        default: ;
      endcase
    endfunction

    function void snap_wall();
      reached = 1;
      case (shape)
        swmc_pkg::SHAPE_FLAT:      wall_z = tgt_z;
        swmc_pkg::SHAPE_CUBOID:    begin wall_x = tgt_x; wall_y = tgt_y; wall_z = tgt_z; end
        swmc_pkg::SHAPE_ELLIPSOID: wall_x = tgt_x;
        default:                   wall_z = st_y;
      endcase
    endfunction

    // Accepted request: advance the wall and queue the expected response
    function void note_request(move_req_t r);
      longint p0[3], p1[3], s;
      longint hi, lo;
      move_rsp_t e;
      hi = 64'sh7FFF_FFFF;
      lo = -hi - 1;
      for (int i = 0; i < 3; i++) begin
        p0[i] = longint'($signed(r.pos[i]));
        s = p0[i] + longint'($signed(r.mv[i]));
        p1[i] = s > hi ? hi : (s < lo ? lo : s);
      end
      if (!reached) begin
        if (r.step < eq_time) begin
          if (r.all_inside && r.step != last_step) begin
            last_step = r.step;
            shrink_wall();
          end
        end else begin
          snap_wall();
        end
      end
      e.accept = 1;
      if (!is_inside(p1) && (reached || shape == swmc_pkg::SHAPE_CUBOID ||
          shape == swmc_pkg::SHAPE_ELLIPSOID || bound_dist(p1) > bound_dist(p0)))
        e.accept = 0;
      e.target_reached = reached;
      expected = {expected, e};
    endfunction

    function void check_result(move_rsp_t got);
      move_rsp_t e;
      if (expected.size() == 0) begin
        $error("response with no request outstanding");
        errors++;
        return;
      end
      e = expected.pop_front();
      if (got.accept !== e.accept) begin
        $error("accept: expected %0b, got %0b", e.accept, got.accept);
        errors++;
      end
      if (got.target_reached !== e.target_reached) begin
        $error("target_reached: expected %0b, got %0b", e.target_reached,
               got.target_reached);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [2:0]  cfg_idx_i;
  logic [30:0] cfg_data_i;

  swmc_req_if req_if();
  swmc_rsp_if rsp_if();

  shrinking_wall_move_check dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .req_i      (req_if),
    .rsp_o      (rsp_if)
  );

  wall_scoreboard sb = new();
  bit             no_gaps;
  int             cycles = 0;
  logic [30:0]    cur_step;
  longint         wall_scale;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Monitors: note accepted requests, check accepted responses
  always @(posedge clk_i) begin
    move_req_t r;
    move_rsp_t g;
    if (rst_ni && req_if.valid && req_if.ready) begin
      r.step = req_if.step;
      r.all_inside = req_if.all_inside;
      r.pos = {req_if.pos_z, req_if.pos_y, req_if.pos_x};
      r.mv = {req_if.move_z, req_if.move_y, req_if.move_x};
      sb.note_request(r);
    end
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      g.accept = rsp_if.accept;
      g.target_reached = rsp_if.target_reached;
      sb.check_result(g);
    end
  end

  // Timeout
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_shrinking_wall_move_check failed");
      $finish;
    end
  end

  // Response side back-pressure
  initial begin
    int stall;
    rsp_if.ready = 1'b0;
    @(posedge clk_i iff rst_ni);
    forever begin
      stall = no_gaps ? 0 : $urandom_range(0, 17);
      if (stall > 0) begin
        rsp_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      rsp_if.ready <= 1'b1;
      do @(posedge clk_i); while (!rsp_if.valid);
    end
  end

  task automatic send_move(move_req_t r);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.step       <= r.step;
    req_if.all_inside <= r.all_inside;
    req_if.pos_x      <= r.pos[0];
    req_if.pos_y      <= r.pos[1];
    req_if.pos_z      <= r.pos[2];
    req_if.move_x     <= r.mv[0];
    req_if.move_y     <= r.mv[1];
    req_if.move_z     <= r.mv[2];
    req_if.valid      <= 1'b1;
    do @(posedge clk_i); while (!req_if.ready);
  endtask

  task automatic drain();
    req_if.valid <= 1'b0;
    while (sb.expected.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
  endtask

  // Program all eight registers while the block is idle
  task automatic set_wall(swmc_pkg::shape_e shp, longint eq, longint tx, longint ty,
                          longint tz, longint sx, longint sy, longint sz);
    logic [30:0] vals[8];
    vals = '{31'(shp), 31'(eq), 31'(tx), 31'(ty), 31'(tz), 31'(sx), 31'(sy), 31'(sz)};
    for (int i = 0; i < 8; i++) begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= swmc_pkg::cfg_idx_e'(i);
      cfg_data_i <= vals[i];
      @(posedge clk_i);
      sb.write_reg(swmc_pkg::cfg_idx_e'(i), vals[i]);
    end
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Coordinate near the wall, now and then anywhere in the full range
  function automatic logic [31:0] near_coord(longint lim);
    longint v;
    if ($urandom_range(0, 9) == 0) return $urandom;
    if (lim > 64'sh7FFF_FFFF) lim = 64'sh7FFF_FFFF;
    v = longint'($urandom_range(0, 32'(lim)));
    return $urandom_range(0, 1) ? 32'(-v) : 32'(v);
  endfunction

  // Random request; step mostly advances, wild steps only when allowed
  task automatic random_move(bit wild_step);
    move_req_t r;
    if (wild_step && $urandom_range(0, 3) == 0) cur_step = 31'($urandom);
    else if ($urandom_range(0, 3) != 0) cur_step = cur_step + 31'd1;
    r.step = cur_step;
    r.all_inside = $urandom_range(0, 7) != 0;
    for (int i = 0; i < 3; i++) begin
      r.pos[i] = near_coord(wall_scale + wall_scale / 3);
      r.mv[i] = near_coord(wall_scale / 8 + 1);
    end
    send_move(r);
  endtask

  task automatic directed_moves();
    logic [31:0] vals[6];
    move_req_t r;
    vals = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFFF, 32'h0001_0000,
             32'h4000_0000};
    for (int k = 0; k < 20; k++) begin
      cur_step = cur_step + 31'd1;
      r.step = cur_step;
      r.all_inside = k[0];
      for (int i = 0; i < 3; i++) begin
        r.pos[i] = vals[(k + i) % 6];
        r.mv[i] = vals[(k * 2 + i + 1) % 6];
      end
      if (k >= 14) begin
        // small points around the shell surface
        r.pos = {32'h0, 32'h0, 32'(wall_scale + (k - 17) * 1000)};
        r.mv = {32'h0, 32'h0, 32'(-(k - 16) * 3000)};
      end
      send_move(r);
    end
  endtask

  initial begin
    longint s;
    rst_ni = 1'b0;
    no_gaps = 0;
    cur_step = 1;
    cfg_we_i = 1'b0;
    cfg_idx_i = swmc_pkg::CFG_SHAPE;
    cfg_data_i = '0;
    req_if.valid = 1'b0;
    req_if.step = '0;
    req_if.all_inside = 1'b0;
    req_if.pos_x = '0; req_if.pos_y = '0; req_if.pos_z = '0;
    req_if.move_x = '0; req_if.move_y = '0; req_if.move_z = '0;
    sb.clear();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int ph = 0; ph < 9; ph++) begin
      s = $urandom_range(32'h0001_0000, 32'h0040_0000);
      wall_scale = s;
      no_gaps = (ph % 3 == 1);
      case (ph)
        // shell, wall never reached until eq time
        0: set_wall(swmc_pkg::SHAPE_SHELL, MAX31, s, s + s / 2, s / 2, s, s / 8, s / 4);
        1: set_wall(swmc_pkg::SHAPE_FLAT, MAX31, s, s, s, s, s, s + 3000 * SHRINK_Q16);
        // cuboid with y start already below its target
        2: set_wall(swmc_pkg::SHAPE_CUBOID, MAX31, s, s, s, s + 1000 * SHRINK_Q16, s / 2,
                    s + 1200 * SHRINK_Q16);
        3: set_wall(swmc_pkg::SHAPE_ELLIPSOID, MAX31, s, s / 2 + 1, s * 2,
                    s + 2000 * SHRINK_Q16, s, s);
        // cuboid snaps at eq time, y snaps to its own target
        4: set_wall(swmc_pkg::SHAPE_CUBOID, cur_step + 40, s, s / 2, s,
                    s + 90 * SHRINK_Q16, s + 70 * SHRINK_Q16, s + 80 * SHRINK_Q16);
        5: set_wall(swmc_pkg::SHAPE_FLAT, '0, MAX31, MAX31, MAX31, MAX31, MAX31, MAX31);
        // zero semi-axis in z
        6: set_wall(swmc_pkg::SHAPE_ELLIPSOID, $urandom, s, s, '0, s, s, s);
        7: set_wall(swmc_pkg::SHAPE_SHELL, '0, '0, '0, '0, '0, '0, '0);
        default: set_wall(swmc_pkg::SHAPE_CUBOID, $urandom, $urandom, $urandom, $urandom,
                          $urandom, $urandom, $urandom);
      endcase
      if (ph == 0) directed_moves();
      for (int n = 0; n < 195; n++) random_move(ph >= 5);
      drain();
    end

    if (sb.errors == 0 && sb.expected.size() == 0)
      $display("tb_shrinking_wall_move_check passed");
    else
      $display("tb_shrinking_wall_move_check failed");
    $finish;
  end

endmodule
